FILE: rtl/bvre_pkg.sv
// ----------------------------------------------------------------------------
// bvre_pkg
// Shared types, widths and codes of the bit vector range engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bvre_pkg;

    localparam int DEF_VECTOR_BITS = 256;
    localparam int DEF_WORD_BITS   = 32;

    localparam int IDX_W = 8;
    localparam int CMD_W = 3;
    localparam int LEN_W = 9;
    localparam int CNT_W = 9;

    localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;

    typedef enum logic [CMD_W-1:0] {
        OP_GET   = 3'd0,
        OP_PUT   = 3'd1,
        OP_SET   = 3'd2,
        OP_CLR   = 3'd3,
        OP_INV   = 3'd4,
        OP_COUNT = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] low_index;
        logic [IDX_W-1:0] high_index;
        logic             write_value;
    } t_cmd_req;

    typedef struct packed {
        logic             bit_out;
        logic [CNT_W-1:0] ones_count;
        logic             range_error;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/bvre_if.sv
// ----------------------------------------------------------------------------
// bvre_if
// Valid/ready channels of the bit vector range engine: command, result
// and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface bvre_cmd_if;
    import bvre_pkg::*;
    logic     valid;
    logic     ready;
    t_cmd_req req;
    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

interface bvre_res_if;
    import bvre_pkg::*;
    logic    valid;
    logic    ready;
    t_result res;
    modport source (output valid, output res, input ready);
    modport sink   (input valid, input res, output ready);
endinterface

interface bvre_cfg_if;
    import bvre_pkg::*;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/bit_vector_range_engine_core.sv
// ----------------------------------------------------------------------------
// bit_vector_range_engine_core
// Bit vector with get, put, range set/clear/invert and population count.
// ----------------------------------------------------------------------------
// usage:
//   i_cmd  - command requests (command, low_index, high_index, write_value)
//   o_res  - one result per request (bit_out, ones_count, range_error)
//   i_cfg  - write of bits_in_use; always ready, starts a fresh all-zero
//            vector, only to be written while no request is in flight
// the vector lives in a word RAM; one word is read, modified and written
// back (get only reads) per cycle by a single sweep unit, the running ones
// count is updated from the popcount difference of that word
// steps from request accept to result valid:
//   count or rejected request : ST_RESULT, output register
//   get/put                   : one word swept, ST_RESULT, output register
//   range over k words        : k words swept, ST_RESULT, output register
// i_cmd is ready again as the result enters the output
// register; a new request is taken while the previous result still waits
// reset and every configuration write run a clear pass over all WORD_COUNT
// words (8 at the defaults) with i_cmd not ready
// a stalled o_res holds its result; a finished sweep then waits for the
// output register before going back to idle
// ----------------------------------------------------------------------------
`default_nettype none

module bit_vector_range_engine_core #(
    parameter int VECTOR_BITS = bvre_pkg::DEF_VECTOR_BITS,
    parameter int WORD_BITS   = bvre_pkg::DEF_WORD_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bvre_cmd_if.sink   i_cmd,
    bvre_cfg_if.sink   i_cfg,
    bvre_res_if.source o_res
);

    import bvre_pkg::*;

    localparam int WORD_COUNT = (VECTOR_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BW         = $clog2(WORD_BITS);
    localparam int IW         = IDX_W + AW;
    localparam int PW         = $clog2(WORD_BITS + 1);

    t_state           r_state, n_state;
    logic [AW-1:0]    r_addr, n_addr;
    logic [CNT_W-1:0] r_pop, n_pop;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;

    logic [CMD_W-1:0] r_cmd, n_cmd;
    logic             r_wv, n_wv;
    logic [AW-1:0]    r_lo_word, n_lo_word;
    logic [AW-1:0]    r_hi_word, n_hi_word;
    logic [BW-1:0]    r_lo_off, n_lo_off;
    logic [BW-1:0]    r_hi_off, n_hi_off;
    logic             r_bit, n_bit;
    logic             r_err, n_err;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [LEN_W-1:0]     act_len;
    logic [IDX_W-1:0]     lo_idx, hi_idx;
    logic                 lo_bad, range_bad, req_bad;
    logic                 req_sweep;

    logic [BW-1:0]        lo_bit, hi_bit;
    logic [WORD_BITS-1:0] mask, new_word;
    logic [PW-1:0]        pc_old, pc_new;

    bvre_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // lengths above capacity act as capacity
    assign act_len = (int'(r_len) > VECTOR_BITS) ? LEN_W'(VECTOR_BITS) : r_len;

    // request decode and index checks
    always_comb begin
        lo_idx    = i_cmd.req.low_index;
        lo_bad    = ({1'b0, lo_idx} >= act_len);
        range_bad = ({1'b0, i_cmd.req.high_index} >= act_len)
                    || (lo_idx > i_cmd.req.high_index);
        hi_idx    = i_cmd.req.high_index;
        req_bad   = 1'b1;
        req_sweep = 1'b0;
        unique case (i_cmd.req.command) inside
            OP_GET, OP_PUT: begin
                hi_idx    = lo_idx;
                req_bad   = lo_bad;
                req_sweep = !lo_bad;
            end
            OP_SET, OP_CLR, OP_INV: begin
                req_bad   = range_bad;
                req_sweep = !range_bad;
            end
            OP_COUNT: begin
                req_bad   = 1'b0;
            end
            default: begin
                req_bad   = 1'b1;
            end
        endcase
    end

    // word update of the sweep unit
    always_comb begin
        lo_bit = (r_addr == r_lo_word) ? r_lo_off : '0;
        hi_bit = (r_addr == r_hi_word) ? r_hi_off : BW'(WORD_BITS - 1);
        mask   = ({WORD_BITS{1'b1}} << lo_bit)
                 & ({WORD_BITS{1'b1}} >> (BW'(WORD_BITS - 1) - hi_bit));
        unique case (r_cmd) inside
            OP_SET:  new_word = ram_rdata | mask;
            OP_CLR:  new_word = ram_rdata & ~mask;
            OP_INV:  new_word = ram_rdata ^ mask;
            OP_PUT:  new_word = r_wv ? (ram_rdata | mask) : (ram_rdata & ~mask);
            default: new_word = ram_rdata;
        endcase
        pc_old = PW'($countones(ram_rdata));
        pc_new = PW'($countones(new_word));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_pop       <= '0;
            r_len       <= LEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_pop       <= n_pop;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_cmd     <= n_cmd;
        r_wv      <= n_wv;
        r_lo_word <= n_lo_word;
        r_hi_word <= n_hi_word;
        r_lo_off  <= n_lo_off;
        r_hi_off  <= n_hi_off;
        r_bit     <= n_bit;
        r_err     <= n_err;
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_pop       = r_pop;
        n_len       = r_len;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_cmd       = r_cmd;
        n_wv        = r_wv;
        n_lo_word   = r_lo_word;
        n_hi_word   = r_hi_word;
        n_lo_off    = r_lo_off;
        n_hi_off    = r_hi_off;
        n_bit       = r_bit;
        n_err       = r_err;

        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = new_word;
        ram_re      = 1'b0;
        ram_raddr   = r_addr + AW'(1);

        i_cmd.ready = (r_state == ST_IDLE);
        i_cfg.ready = 1'b1;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (r_addr == AW'(WORD_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd     = i_cmd.req.command;
                    n_wv      = i_cmd.req.write_value;
                    n_lo_word = AW'(IW'(lo_idx) / WORD_BITS);
                    n_hi_word = AW'(IW'(hi_idx) / WORD_BITS);
                    n_lo_off  = BW'(lo_idx % WORD_BITS);
                    n_hi_off  = BW'(hi_idx % WORD_BITS);
                    n_bit     = 1'b0;
                    n_err     = req_bad;
                    if (req_sweep) begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(IW'(lo_idx) / WORD_BITS);
                        n_addr    = AW'(IW'(lo_idx) / WORD_BITS);
                        n_state   = ST_SWEEP;
                    end else begin
                        n_state   = ST_RESULT;
                    end
                end
            end
            ST_SWEEP: begin
                ram_we = (r_cmd != OP_GET);
                n_pop  = r_pop + CNT_W'(pc_new) - CNT_W'(pc_old);
                if (r_cmd == OP_GET || r_cmd == OP_PUT) begin
                    n_bit = |(ram_rdata & mask);
                end
                if (r_addr == r_hi_word) begin
                    n_state = ST_RESULT;
                end else begin
                    // next word read overlaps the write of this one
                    ram_re = 1'b1;
                    n_addr = r_addr + AW'(1);
                end
            end
            ST_RESULT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out.bit_out     = r_bit;
                    n_out.ones_count  = r_pop;
                    n_out.range_error = r_err;
                    n_out_valid       = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // a new length starts a fresh, cleared vector
        if (i_cfg.valid) begin
            n_len   = i_cfg.data;
            n_pop   = '0;
            n_addr  = '0;
            n_state = ST_CLEAR;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.res   = r_out;

`ifndef SYNTHESIS
    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready && !i_cfg.valid)
        |=> (r_state == ST_SWEEP || r_state == ST_RESULT))
        else $error("accepted request did not start work");

    a_sweep_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> (r_addr >= r_lo_word && r_addr <= r_hi_word))
        else $error("sweep address outside requested words");

    a_write_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_SWEEP || r_state == ST_CLEAR))
        else $error("store written outside sweep or clear");

    a_error_bit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.res.range_error && o_res.res.bit_out))
        else $error("rejected request returned a bit");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT && !r_out_valid && !i_cfg.valid) |=> o_res.valid)
        else $error("result not moved to output register");
`endif

endmodule

`default_nettype wire

FILE: rtl/bvre_ram.sv
// ----------------------------------------------------------------------------
// bvre_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bvre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
